// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define WSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define WSA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/wsa_pkg.sv =====
// ---------------------------------------------------------------------------
// wsa_pkg
// Constants, codes and saturating helpers of the window statistics block.
// ---------------------------------------------------------------------------
package wsa_pkg;

    localparam int RESERVOIR_DEPTH_DEF = 16;

    // operation codes carried in tuser
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;   // unused code, ignored

    // aggregate modes
    localparam logic [2:0] MODE_MIN    = 3'd0;
    localparam logic [2:0] MODE_MAX    = 3'd1;
    localparam logic [2:0] MODE_SUM    = 3'd2;
    localparam logic [2:0] MODE_DELTA  = 3'd3;
    localparam logic [2:0] MODE_MEDIAN = 3'd4;
    localparam logic [2:0] MODE_MEAN   = 3'd5;
    localparam logic [2:0] MODE_VAR    = 3'd6;
    localparam logic [2:0] MODE_STDEV  = 3'd7;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_RSIZE = 1'b1;

    localparam logic [4:0] RSIZE_RESET = 5'd16;

    // signed 64-bit add, saturating
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    // signed 64-bit subtract, saturating
    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

endpackage

// ===== src/window_statistics_aggregator_core.sv =====
// ---------------------------------------------------------------------------
// window_statistics_aggregator_core
// Windowed min/max/sum/delta/median/mean/variance/stdev over Q16.16 samples.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                         | tuser
//  s_       | in  | [31:0] sample, [63:32] slot   | [1:0] op
//  m_       | out | [63:0] value (Q47.16)         | [0] valid_res
//  cfg_     | in  | cfg_addr 0 mode, 1 reservoir_size
//
//  Work per item: adds in min/max/sum/delta/median finish in the exec state;
//  a Welford add uses a 64-step divider and a 4-step multiplier; variance reads
//  use the divider, stdev also a 40-step square root, median an insertion sort.
//  One item is worked on at a time; the result register frees the input side.
//  Reset: synchronous, active low; no clearing pass.
// ---------------------------------------------------------------------------
module window_statistics_aggregator_core #(
    parameter int RESERVOIR_DEPTH = wsa_pkg::RESERVOIR_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] sample, [63:32] replace_slot
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic        m_tuser,   // [0] valid_res
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_wdata
);
    import wsa_pkg::*;

    localparam int AW   = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
    localparam int CW   = $clog2(RESERVOIR_DEPTH + 1);
    localparam int LIMW = (CW > 5) ? CW : 5;

    typedef enum logic [17:0] {
        ST_IDLE   = 18'h00001,
        ST_EXEC   = 18'h00002,
        ST_DIV    = 18'h00004,
        ST_WMEAN  = 18'h00008,
        ST_WD2    = 18'h00010,
        ST_MUL    = 18'h00020,
        ST_WM2    = 18'h00040,
        ST_WACC   = 18'h00080,
        ST_VAR    = 18'h00100,
        ST_SQRT   = 18'h00200,
        ST_SORT_I = 18'h00400,
        ST_SORT_X = 18'h00800,
        ST_SORT_C = 18'h01000,
        ST_SORT_W = 18'h02000,
        ST_MED_A  = 18'h04000,
        ST_MED_B  = 18'h08000,
        ST_MED_C  = 18'h10000,
        ST_RESULT = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  mode_reg, mode_next;
    logic [4:0]  rsize_reg, rsize_next;
    logic signed [63:0] prim_reg, prim_next;
    logic signed [63:0] sec_reg, sec_next;
    logic signed [63:0] carry_val_reg, carry_val_next;
    logic        carry_act_reg, carry_act_next;
    logic [31:0] count_reg, count_next;
    logic [CW-1:0] slots_used_reg, slots_used_next;

    // latched item
    logic [1:0]  op_reg, op_next;
    logic signed [31:0] samp_reg, samp_next;
    logic [31:0] slot_reg, slot_next;

    // divider
    logic signed [63:0] d1_reg, d1_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic        for_var_reg, for_var_next;
    logic [5:0]  cnt_reg, cnt_next;

    // multiplier
    logic [63:0]  ma_reg, ma_next;
    logic [63:0]  mb_reg, mb_next;
    logic [127:0] prod_reg, prod_next;
    logic         mneg_reg, mneg_next;
    logic signed [63:0] mq_reg, mq_next;

    // square root
    logic [79:0] sx_reg, sx_next;
    logic [41:0] srem_reg, srem_next;
    logic [39:0] sroot_reg, sroot_next;

    // sort / median
    logic [CW-1:0] si_reg, si_next;
    logic [CW-1:0] sj_reg, sj_next;
    logic signed [31:0] xv_reg, xv_next;
    logic signed [31:0] lat0_reg, lat0_next;

    // result staging and output beat
    logic signed [63:0] res_val_reg, res_val_next;
    logic        res_ok_reg, res_ok_next;
    logic [63:0] out_val_reg, out_val_next;
    logic        out_ok_reg, out_ok_next;
    logic        out_vld_reg, out_vld_next;

    // reservoir memory
    logic signed [31:0] mem [RESERVOIR_DEPTH];
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata, mem_rdata;

    logic signed [63:0] samp64, quot;
    logic [LIMW-1:0] lim;
    logic [31:0] count_inc;
    logic [33:0] rem_sh;
    logic        rem_ge;
    logic [63:0] pp;
    logic [127:0] pp_sh;
    logic [63:0] mr;
    logic signed [63:0] d2;
    logic [41:0] srem_sh, strial;
    logic [CW-1:0] mid;
    logic signed [32:0] msum;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_ok_reg;

    // reservoir: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // helpers
    always_comb begin
        samp64    = {{32{samp_reg[31]}}, samp_reg};
        quot      = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
        count_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;
        if (rsize_reg == 5'd0)
            lim = LIMW'(1);
        else if (LIMW'(rsize_reg) > LIMW'(RESERVOIR_DEPTH))
            lim = LIMW'(RESERVOIR_DEPTH);
        else
            lim = LIMW'(rsize_reg);
        rem_sh = {rem_reg[32:0], dvd_reg[63]};
        rem_ge = (rem_sh >= {1'b0, dvs_reg});
        pp     = 64'(cnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0])
               * 64'(cnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0]);
        pp_sh  = {64'd0, pp} << (7'd32 * (7'(cnt_reg[0]) + 7'(cnt_reg[1])));
        mr     = prod_reg[79:16];
        d2     = sat_sub(samp64, prim_reg);
        srem_sh = {srem_reg[39:0], sx_reg[79:78]};
        strial  = {sroot_reg, 2'b01};
        mid     = slots_used_reg >> 1;
        msum    = {lat0_reg[31], lat0_reg} + {mem_rdata[31], mem_rdata};
    end

    // control and datapath
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        rsize_next      = rsize_reg;
        prim_next       = prim_reg;
        sec_next        = sec_reg;
        carry_val_next  = carry_val_reg;
        carry_act_next  = carry_act_reg;
        count_next      = count_reg;
        slots_used_next = slots_used_reg;
        op_next         = op_reg;
        samp_next       = samp_reg;
        slot_next       = slot_reg;
        d1_next         = d1_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        neg_next        = neg_reg;
        for_var_next    = for_var_reg;
        cnt_next        = cnt_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        prod_next       = prod_reg;
        mneg_next       = mneg_reg;
        mq_next         = mq_reg;
        sx_next         = sx_reg;
        srem_next       = srem_reg;
        sroot_next      = sroot_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        xv_next         = xv_reg;
        lat0_next       = lat0_reg;
        res_val_next    = res_val_reg;
        res_ok_next     = res_ok_reg;
        out_val_next    = out_val_reg;
        out_ok_next     = out_ok_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = samp_reg;
        mem_raddr       = '0;

        // configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MODE:  mode_next  = cfg_wdata[2:0];
                CFG_RSIZE: rsize_next = cfg_wdata;
                default:   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    samp_next  = s_tdata[31:0];
                    slot_next  = s_tdata[63:32];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_IDLE;
                unique case (op_reg)
                    OP_ADD: begin
                        count_next = count_inc;
                        unique case (mode_reg)
                            MODE_MIN:
                                if (count_reg == '0 || samp64 < prim_reg) prim_next = samp64;
                            MODE_MAX:
                                if (count_reg == '0 || samp64 > prim_reg) prim_next = samp64;
                            MODE_SUM:
                                prim_next = sat_add(prim_reg, samp64);
                            MODE_DELTA: begin
                                if (count_reg == '0)
                                    prim_next = carry_act_reg ? carry_val_reg : samp64;
                                sec_next = samp64;
                            end
                            MODE_MEDIAN: begin
                                if (LIMW'(slots_used_reg) < lim) begin
                                    mem_we          = 1'b1;
                                    mem_waddr       = slots_used_reg[AW-1:0];
                                    slots_used_next = slots_used_reg + CW'(1);
                                end else if (slot_reg < 32'(lim)) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = slot_reg[AW-1:0];
                                end
                            end
                            default: begin
                                // Welford: count advances together with the M2 update
                                count_next   = count_reg;
                                d1_next      = sat_sub(samp64, prim_reg);
                                dvd_next     = mag64(sat_sub(samp64, prim_reg));
                                neg_next     = samp64 < prim_reg;
                                dvs_next     = 33'(count_reg) + 33'd1;
                                rem_next     = '0;
                                cnt_next     = '0;
                                for_var_next = 1'b0;
                                state_next   = ST_DIV;
                            end
                        endcase
                    end
                    OP_CLEAR: begin
                        carry_act_next  = 1'b1;
                        carry_val_next  = sec_reg;
                        prim_next       = '0;
                        sec_next        = '0;
                        count_next      = '0;
                        slots_used_next = '0;
                    end
                    OP_READ: begin
                        state_next   = ST_RESULT;
                        res_val_next = '0;
                        res_ok_next  = 1'b0;
                        unique case (mode_reg)
                            MODE_MIN, MODE_MAX, MODE_MEAN: begin
                                res_ok_next  = (count_reg != '0);
                                res_val_next = (count_reg != '0) ? prim_reg : '0;
                            end
                            MODE_SUM: begin
                                res_ok_next  = 1'b1;
                                res_val_next = (count_reg != '0) ? prim_reg : '0;
                            end
                            MODE_DELTA: begin
                                res_ok_next  = 1'b1;
                                res_val_next = (count_reg != '0) ? sat_sub(sec_reg, prim_reg)
                                                                 : '0;
                            end
                            MODE_MEDIAN: begin
                                if (count_reg != '0 && slots_used_reg != '0) begin
                                    si_next    = CW'(1);
                                    state_next = ST_SORT_I;
                                end
                            end
                            default: begin
                                if (count_reg > 32'd1) begin
                                    dvd_next     = mag64(sec_reg);
                                    neg_next     = sec_reg[63];
                                    dvs_next     = 33'(count_reg) - 33'd1;
                                    rem_next     = '0;
                                    cnt_next     = '0;
                                    for_var_next = 1'b1;
                                    state_next   = ST_DIV;
                                end
                            end
                        endcase
                    end
                    default: ;
                endcase
            end

            // restoring divide, one quotient bit a cycle
            ST_DIV: begin
                rem_next = rem_ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                dvd_next = {dvd_reg[62:0], rem_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = for_var_reg ? ST_VAR : ST_WMEAN;
            end

            ST_WMEAN: begin
                prim_next  = sat_add(prim_reg, quot);
                state_next = ST_WD2;
            end

            ST_WD2: begin
                ma_next    = mag64(d1_reg);
                mb_next    = mag64(d2);
                mneg_next  = d1_reg[63] ^ d2[63];
                prod_next  = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
            end

            // 64x64 magnitude product from four 32x32 partials
            ST_MUL: begin
                prod_next = prod_reg + pp_sh;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd3)
                    state_next = ST_WM2;
            end

            // shift by 16 and saturate
            ST_WM2: begin
                if (prod_reg[127:80] != '0)
                    mq_next = mneg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else if (mneg_reg)
                    mq_next = mr[63] ? {1'b1, 63'd0} : -$signed(mr);
                else
                    mq_next = mr[63] ? {1'b0, {63{1'b1}}} : $signed(mr);
                state_next = ST_WACC;
            end

            ST_WACC: begin
                sec_next   = sat_add(sec_reg, mq_reg);
                count_next = count_inc;
                state_next = ST_IDLE;
            end

            ST_VAR: begin
                state_next = ST_RESULT;
                if (mode_reg == MODE_VAR) begin
                    res_val_next = quot;
                    res_ok_next  = 1'b1;
                end else if (quot[63]) begin
                    res_val_next = '0;
                    res_ok_next  = 1'b0;
                end else begin
                    sx_next    = {quot[63:0], 16'd0};
                    srem_next  = '0;
                    sroot_next = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end

            // digit-by-digit square root, two radicand bits a cycle
            ST_SQRT: begin
                if (srem_sh >= strial) begin
                    srem_next  = srem_sh - strial;
                    sroot_next = {sroot_reg[38:0], 1'b1};
                end else begin
                    srem_next  = srem_sh;
                    sroot_next = {sroot_reg[38:0], 1'b0};
                end
                sx_next  = {sx_reg[77:0], 2'b00};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd39) begin
                    res_val_next = $signed({24'd0, sroot_next});
                    res_ok_next  = 1'b1;
                    state_next   = ST_RESULT;
                end
            end

            // insertion sort in place
            ST_SORT_I: begin
                if (si_reg >= slots_used_reg) begin
                    state_next = ST_MED_A;
                end else begin
                    mem_raddr  = si_reg[AW-1:0];
                    state_next = ST_SORT_X;
                end
            end

            ST_SORT_X: begin
                xv_next    = mem_rdata;
                sj_next    = si_reg;
                mem_raddr  = AW'(si_reg - CW'(1));
                state_next = ST_SORT_C;
            end

            ST_SORT_C: begin
                if (mem_rdata > xv_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = sj_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                    sj_next   = sj_reg - CW'(1);
                    if (sj_reg > CW'(1))
                        mem_raddr = AW'(sj_reg - CW'(2));
                    else
                        state_next = ST_SORT_W;
                end else begin
                    state_next = ST_SORT_W;
                end
            end

            ST_SORT_W: begin
                mem_we     = 1'b1;
                mem_waddr  = sj_reg[AW-1:0];
                mem_wdata  = xv_reg;
                si_next    = si_reg + CW'(1);
                state_next = ST_SORT_I;
            end

            ST_MED_A: begin
                mem_raddr  = slots_used_reg[0] ? mid[AW-1:0] : AW'(mid - CW'(1));
                state_next = ST_MED_B;
            end

            ST_MED_B: begin
                if (slots_used_reg[0]) begin
                    res_val_next = {{32{mem_rdata[31]}}, mem_rdata};
                    res_ok_next  = 1'b1;
                    state_next   = ST_RESULT;
                end else begin
                    lat0_next  = mem_rdata;
                    mem_raddr  = mid[AW-1:0];
                    state_next = ST_MED_C;
                end
            end

            // floor of half the sum
            ST_MED_C: begin
                res_val_next = {{32{msum[32]}}, msum[32:1]};
                res_ok_next  = 1'b1;
                state_next   = ST_RESULT;
            end

            ST_RESULT: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next = 1'b1;
                    out_val_next = res_val_reg;
                    out_ok_next  = res_ok_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_MIN;
            rsize_reg      <= RSIZE_RESET;
            prim_reg       <= '0;
            sec_reg        <= '0;
            carry_val_reg  <= '0;
            carry_act_reg  <= 1'b0;
            count_reg      <= '0;
            slots_used_reg <= '0;
            out_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            rsize_reg      <= rsize_next;
            prim_reg       <= prim_next;
            sec_reg        <= sec_next;
            carry_val_reg  <= carry_val_next;
            carry_act_reg  <= carry_act_next;
            count_reg      <= count_next;
            slots_used_reg <= slots_used_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        samp_reg    <= samp_next;
        slot_reg    <= slot_next;
        d1_reg      <= d1_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        neg_reg     <= neg_next;
        for_var_reg <= for_var_next;
        cnt_reg     <= cnt_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        prod_reg    <= prod_next;
        mneg_reg    <= mneg_next;
        mq_reg      <= mq_next;
        sx_reg      <= sx_next;
        srem_reg    <= srem_next;
        sroot_reg   <= sroot_next;
        si_reg      <= si_next;
        sj_reg      <= sj_next;
        xv_reg      <= xv_next;
        lat0_reg    <= lat0_next;
        res_val_reg <= res_val_next;
        res_ok_reg  <= res_ok_next;
        out_val_reg <= out_val_next;
        out_ok_reg  <= out_ok_next;
    end

    // checks
    `include "assert_macros.svh"
    `WSA_ASSERT_IMP(a_slots_bound, aclk, aresetn, 1'b1, LIMW'(slots_used_reg) <= LIMW'(RESERVOIR_DEPTH))
    `WSA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `WSA_ASSERT_IMP(a_out_from_result, aclk, aresetn, $rose(m_tvalid), $past(state_reg == ST_RESULT))

endmodule
